// ===== rtl/lbip_pkg.sv =====
package lbip_pkg;

  typedef struct packed {
    logic        mode;
    logic [63:0] lookup_key;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [31:0] range_block;
  } in_t;

  typedef struct packed {
    logic [31:0] block_number;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic [63:0] start_key;
    logic [63:0] end_key;
    logic [31:0] block_number;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  localparam logic [7:0] REG_MODEL_TYPE  = 8'd0;
  localparam logic [7:0] REG_COEF_COUNT  = 8'd1;
  localparam logic [7:0] REG_COEF_ZERO   = 8'd2;
  localparam logic [7:0] REG_COEF_ONE    = 8'd3;
  localparam logic [7:0] REG_COEF_TWO    = 8'd4;
  localparam logic [7:0] REG_COEF_THREE  = 8'd5;

  localparam logic       MODE_INSERT     = 1'b0;
  localparam logic       MODE_LOOKUP     = 1'b1;
  localparam logic [1:0] MODEL_LINEAR    = 2'd0;
  localparam logic [1:0] MODEL_POLY      = 2'd1;

endpackage

// ===== rtl/learned_block_index_predictor_core.sv =====
// Range table plus model predictor. An insert walks the table from its end,
// moving one entry up per read and compare step until its slot is found; when
// the table is full the word is dropped and table_full is flagged. A lookup
// with a model runs Horner steps on one shift-add unit, then scans the table
// entry by entry when the table answer is needed. One item is in work at a
// time; the result sits in an output register so the next word can be
// accepted while it waits. Configuration writes are always ready.
module learned_block_index_predictor_core #(
  parameter int unsigned TABLE_DEPTH      = 64,
  parameter int unsigned MAX_COEFFICIENTS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lbip_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lbip_pkg::out_t   out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);
  import lbip_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned W  = 64 * MAX_COEFFICIENTS + 8;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
  localparam logic [3:0] MAXC = 4'(MAX_COEFFICIENTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_NEW = 4'd3;
  localparam logic [3:0] S_MDL_MUL = 4'd4;
  localparam logic [3:0] S_MDL_ADD = 4'd5;
  localparam logic [3:0] S_MDL_END = 4'd6;
  localparam logic [3:0] S_SCAN_RD = 4'd7;
  localparam logic [3:0] S_SCAN_CK = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    mtype_q;
  logic [2:0]    ccount_q;
  logic [63:0]   coef_q [4];

  in_t           item_q, item_d;
  logic [AW-1:0] k_q, k_d;
  logic [W-1:0]  acc_q, acc_d, prod_q, prod_d;
  logic [5:0]    bit_q, bit_d;
  logic [3:0]    cidx_q, cidx_d;
  logic [63:0]   prev_end_q, prev_end_d;
  logic [31:0]   prev_blk_q, prev_blk_d;
  out_t          res_q, res_d, out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rd;
  logic [EntryW-1:0] rdata_raw;

  lbip_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (EntryW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rd = entry_t'(rdata_raw);

  function automatic logic [W-1:0] coef_ext(input logic [3:0] idx, input logic [63:0] c0,
                                            input logic [63:0] c1, input logic [63:0] c2,
                                            input logic [63:0] c3);
    logic [63:0] c;
    case (idx)
      4'd0:    c = c0;
      4'd1:    c = c1;
      4'd2:    c = c2;
      4'd3:    c = c3;
      default: c = 64'd0;
    endcase
    return {{(W-64){c[63]}}, c};
  endfunction

  entry_t      new_entry;
  logic [3:0]  neff;
  logic [31:0] pval;
  logic [63:0] key;

  assign new_entry = '{start_key: item_q.range_start, end_key: item_q.range_end,
                       block_number: item_q.range_block};
  assign key = item_q.lookup_key;

  always_comb begin
    if ({1'b0, ccount_q} > MAXC) neff = MAXC;
    else neff = {1'b0, ccount_q};
  end

  always_comb begin
    if (acc_q[W-1]) pval = 32'd0;
    else if (|acc_q[W-2:64]) pval = 32'hFFFF_FFFF;
    else pval = acc_q[63:32];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [3:0] n;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    k_d         = k_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    bit_d       = bit_q;
    cidx_d      = cidx_q;
    prev_end_d  = prev_end_q;
    prev_blk_d  = prev_blk_q;
    res_d       = res_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = new_entry;
    raddr       = k_q;
    n           = 4'd0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          if (in_data_i.mode == MODE_INSERT) begin
            if (cnt_q == FULL) begin
              res_d.table_full = 1'b1;
              state_d = S_DONE;
            end else begin
              k_d = cnt_q[AW-1:0];
              state_d = (cnt_q == '0) ? S_INS_NEW : S_INS_RD;
            end
          end else if (ccount_q == 3'd0 || mtype_q > MODEL_POLY) begin
            k_d = '0;
            state_d = (cnt_q == '0) ? S_DONE : S_SCAN_RD;
          end else if (mtype_q == MODEL_LINEAR && ccount_q < 3'd2) begin
            state_d = S_DONE;
          end else begin
            n      = (mtype_q == MODEL_LINEAR) ? 4'd2 : neff;
            acc_d  = coef_ext(n - 4'd1, coef_q[0], coef_q[1], coef_q[2], coef_q[3]);
            cidx_d = n - 4'd1;
            prod_d = '0;
            bit_d  = 6'd63;
            state_d = (n == 4'd1) ? S_MDL_END : S_MDL_MUL;
          end
        end
      end
      S_INS_RD: begin
        raddr   = k_q - AW'(1);
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd.start_key > item_q.range_start) begin
          wdata   = rd;
          k_d     = k_q - AW'(1);
          state_d = (k_q == AW'(1)) ? S_INS_NEW : S_INS_RD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_DONE;
        end
      end
      S_INS_NEW: begin
        we      = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end
      S_MDL_MUL: begin
        // MSB-first shift-add of acc times key
        prod_d = (prod_q << 1) + (key[bit_q] ? acc_q : '0);
        bit_d  = bit_q - 6'd1;
        if (bit_q == 6'd0) state_d = S_MDL_ADD;
      end
      S_MDL_ADD: begin
        acc_d  = prod_q + coef_ext(cidx_q - 4'd1, coef_q[0], coef_q[1], coef_q[2], coef_q[3]);
        cidx_d = cidx_q - 4'd1;
        prod_d = '0;
        bit_d  = 6'd63;
        state_d = (cidx_q == 4'd1) ? S_MDL_END : S_MDL_MUL;
      end
      S_MDL_END: begin
        if (cnt_q != '0 && pval >= 32'(cnt_q)) begin
          k_d     = '0;
          state_d = S_SCAN_RD;
        end else begin
          res_d.block_number = pval;
          state_d = S_DONE;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (rd.end_key >= key) begin
          // nearest neighbor, tie to the earlier range
          if (key >= rd.start_key || k_q == '0) res_d.block_number = rd.block_number;
          else if ((key - prev_end_q) <= (rd.start_key - key))
            res_d.block_number = prev_blk_q;
          else res_d.block_number = rd.block_number;
          state_d = S_DONE;
        end else begin
          prev_end_d = rd.end_key;
          prev_blk_d = rd.block_number;
          if (CW'(k_q) == cnt_q - CW'(1)) begin
            res_d.block_number = rd.block_number;
            state_d = S_DONE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      mtype_q     <= 2'd0;
      ccount_q    <= 3'd0;
      coef_q[0]   <= '0;
      coef_q[1]   <= '0;
      coef_q[2]   <= '0;
      coef_q[3]   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MODEL_TYPE: mtype_q   <= cfg_data_i[1:0];
          REG_COEF_COUNT: ccount_q  <= cfg_data_i[2:0];
          REG_COEF_ZERO:  coef_q[0] <= cfg_data_i;
          REG_COEF_ONE:   coef_q[1] <= cfg_data_i;
          REG_COEF_TWO:   coef_q[2] <= cfg_data_i;
          REG_COEF_THREE: coef_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    bit_q      <= bit_d;
    cidx_q     <= cidx_d;
    prev_end_q <= prev_end_d;
    prev_blk_q <= prev_blk_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

// ===== rtl/lbip_ram.sv =====
module lbip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
